// File: sv/frm_pkg.sv
// frm_pkg: widths and constants for the frame rate meter
// no dependencies; imported by frame_rate_meter_core

package frm_pkg;

    // input and result field widths
    localparam int ELAPSED_W = 32;
    localparam int DELTA_W   = 24;
    localparam int RATE_W    = 28;
    localparam int FRAME_W   = 64;

    // averaging window
    localparam int WINDOW_DEPTH = 32;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = RATE_W + SLOT_W + 1;

    // shared divider: quotient register holds the widest numerator
    localparam int QUO_W  = SUM_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    // 1e6 frames per second scaled by 256 (Q.8)
    localparam logic [RATE_W-1:0] RATE_NUMERATOR = RATE_W'(256000000);

    // clamp register reset value
    localparam logic [DELTA_W-1:0] MAX_DELTA_RESET = DELTA_W'(250000);

endpackage

// File: sv/frame_rate_meter_core.sv
// frame_rate_meter_core: sliding-window frame rate meter, top level
// depends on frm_pkg

// Each request carries one frame duration in microseconds. It is clamped to the
// max-delta register, turned into an instant rate of 256000000 / delta (Q.8 frames
// per second, 0 for a zero delta), stored in a 32-slot ring memory and folded into
// a running sum; the result gives the clamped delta, the window mean (sum divided
// by the number of filled slots) and the 64-bit frame number. One request is in
// work at a time. The rate quotient and then the mean are worked out on one shared
// bit-per-cycle restoring divider, with the memory read-modify-write between them;
// the result is then loaded into the output register once that register is free.
// A finished result sits
// in the output register, so the next request is taken while it waits; a result
// still held there when the next one is done holds the sequencer until it drains.
// The window memory needs no clearing pass: slots not yet reached by the fill
// count read as zero.

module frame_rate_meter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [frm_pkg::DELTA_W-1:0]   i_cfg_wr_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [frm_pkg::ELAPSED_W-1:0] i_elapsed_us,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [frm_pkg::DELTA_W-1:0]   o_delta_us,
    output logic [frm_pkg::RATE_W-1:0]    o_average_rate,
    output logic [frm_pkg::FRAME_W-1:0]   o_frame_number
);

    import frm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDIV   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_ADIV   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [DELTA_W-1:0]  r_max_delta;
    logic [DELTA_W-1:0]  r_delta, n_delta;
    logic                r_delta_zero, n_delta_zero;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [FRAME_W-1:0]  r_frames, n_frames;

    // divider registers
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [DELTA_W-1:0]  r_rem, n_rem;
    logic [DELTA_W-1:0]  r_div, n_div;
    logic [STEP_W-1:0]   r_step, n_step;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [DELTA_W-1:0]  r_out_delta, n_out_delta;
    logic [RATE_W-1:0]   r_out_avg, n_out_avg;
    logic [FRAME_W-1:0]  r_out_frame, n_out_frame;

    // window memory
    logic [RATE_W-1:0]   r_rate_mem [WINDOW_DEPTH];
    logic [RATE_W-1:0]   r_rd_data;
    logic                mem_we;
    logic [RATE_W-1:0]   mem_wdata;

    logic                in_accept;
    logic                out_free;
    logic [DELTA_W:0]    rem_shift;
    logic [DELTA_W:0]    rem_diff;
    logic [RATE_W-1:0]   rate;
    logic [RATE_W-1:0]   old_rate;
    logic                win_full;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign win_full  = (r_fill == FILL_W'(WINDOW_DEPTH));

    // one restoring divider step
    assign rem_shift = {r_rem, r_quo[QUO_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_div};

    // rate quotient sits in the low bits once the rate division is done
    assign rate     = r_delta_zero ? '0 : r_quo[RATE_W-1:0];
    // slots beyond the fill count have never been written and count as zero
    assign old_rate = win_full ? r_rd_data : '0;

    assign mem_we    = (r_state == S_UPDATE);
    assign mem_wdata = rate;

    // sequencer and datapath
    always_comb begin
        n_state      = r_state;
        n_delta      = r_delta;
        n_delta_zero = r_delta_zero;
        n_slot       = r_slot;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_frames     = r_frames;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_out_delta  = r_out_delta;
        n_out_avg    = r_out_avg;
        n_out_frame  = r_out_frame;

        // output taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (in_accept) begin
                    // clamp and start the rate division
                    if (i_elapsed_us < {{(ELAPSED_W-DELTA_W){1'b0}}, r_max_delta}) begin
                        n_delta = i_elapsed_us[DELTA_W-1:0];
                    end else begin
                        n_delta = r_max_delta;
                    end
                    n_delta_zero = (n_delta == '0);
                    n_quo        = {RATE_NUMERATOR, {(QUO_W-RATE_W){1'b0}}};
                    n_rem        = '0;
                    n_div        = n_delta;
                    n_step       = STEP_W'(RATE_W);
                    n_state      = S_RDIV;
                end
            end
            S_RDIV, S_ADIV: begin
                if (!rem_diff[DELTA_W]) begin
                    n_rem = rem_diff[DELTA_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_shift[DELTA_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    n_state = (r_state == S_RDIV) ? S_UPDATE : S_DONE;
                end
            end
            S_UPDATE: begin
                // read-modify-write of the slot and the running sum
                n_sum    = r_sum - SUM_W'(old_rate) + SUM_W'(rate);
                n_slot   = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                n_fill   = win_full ? r_fill : r_fill + 1'b1;
                n_frames = r_frames + 1'b1;
                // start the mean division
                n_quo    = n_sum;
                n_rem    = '0;
                n_div    = DELTA_W'(n_fill);
                n_step   = STEP_W'(QUO_W);
                n_state  = S_ADIV;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_delta = r_delta;
                    n_out_avg   = r_quo[RATE_W-1:0];
                    n_out_frame = r_frames;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_delta <= MAX_DELTA_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_frames    <= n_frames;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_max_delta <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_delta      <= n_delta;
        r_delta_zero <= n_delta_zero;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_out_delta  <= n_out_delta;
        r_out_avg    <= n_out_avg;
        r_out_frame  <= n_out_frame;
    end

    // window memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rate_mem[r_slot] <= mem_wdata;
        end
        r_rd_data <= r_rate_mem[r_slot];
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_delta_us     = r_out_delta;
    assign o_average_rate = r_out_avg;
    assign o_frame_number = r_out_frame;

endmodule
